>>> hw/rtl/sit_pkg.sv
package sit_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int FIELD_WIDTH = 32;

    typedef struct packed {
        logic neg;
        logic hit;
        logic zero;
        logic ovf;
    } sit_flags_t;

endpackage

>>> hw/rtl/sit_div_cell.sv
module sit_div_cell
    import sit_pkg::*;
#(
    parameter int CW  = COORD_WIDTH,
    parameter int XW  = 2 * CW + 3,
    parameter int RW  = XW + FRAC_BITS + CW,
    parameter int BIT = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [RW-1:0]   rem_in,
    input  logic [XW-1:0]   dmag_in,
    input  logic [CW-1:0]   quo_in,
    input  sit_flags_t      flags_in,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [RW-1:0]   rem_out,
    output logic [XW-1:0]   dmag_out,
    output logic [CW-1:0]   quo_out,
    output sit_flags_t      flags_out
);

    logic            valid_reg;
    logic            valid_next;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   rem_next;
    logic [XW-1:0]   dmag_reg;
    logic [CW-1:0]   quo_reg;
    logic [CW-1:0]   quo_next;
    sit_flags_t      flags_reg;
    logic [RW:0]     trial;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        trial    = {1'b0, rem_in} - ({1'b0, RW'(dmag_in)} << BIT);
        rem_next = rem_in;
        quo_next = quo_in;
        if (!trial[RW])
        begin
            rem_next      = trial[RW-1:0];
            quo_next[BIT] = 1'b1;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg   <= rem_next;
            dmag_reg  <= dmag_in;
            quo_reg   <= quo_next;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign dmag_out  = dmag_reg;
    assign quo_out   = quo_reg;
    assign flags_out = flags_reg;

endmodule

>>> hw/rtl/segment_intersection_test_unit.sv
// Fixed-point 2D segment crossing test. Accepts one transaction per clock while
// in_ready is high and returns u_param and hit through five front stages that
// form differences, products, cross products, signs and the hit and overflow
// compares, then a row of COORD_WIDTH restoring divider cells that each settle
// one quotient bit, and an output register that applies sign and saturation.
// Each stage holds its data under backpressure, so the pipeline keeps filling
// while a result waits.
module segment_intersection_test_unit
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = sit_pkg::FRAC_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FIELD_WIDTH-1:0] p1_x,
    input  logic [FIELD_WIDTH-1:0] p1_y,
    input  logic [FIELD_WIDTH-1:0] p2_x,
    input  logic [FIELD_WIDTH-1:0] p2_y,
    input  logic [FIELD_WIDTH-1:0] q1_x,
    input  logic [FIELD_WIDTH-1:0] q1_y,
    input  logic [FIELD_WIDTH-1:0] q2_x,
    input  logic [FIELD_WIDTH-1:0] q2_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [FIELD_WIDTH-1:0] u_param,
    output logic                   hit
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 2;
    localparam int XW = 2 * CW + 3;
    localparam int RW = XW + FRAC_BITS + CW;
    localparam int NS = 5;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] rdy;
    logic [NS-1:0] src_v;
    logic          cells_ready;

    logic signed [DW-1:0] rx_reg, ry_reg, sx_reg, sy_reg, wx_reg, wy_reg;
    logic signed [PW-1:0] m_rxsy_reg, m_rysx_reg, m_wxsy_reg, m_wysx_reg;
    logic signed [PW-1:0] m_wxry_reg, m_wyrx_reg;
    logic signed [XW-1:0] d_reg, nt_reg, nu_reg;
    logic signed [XW-1:0] dmag3_reg, ntn_reg, nun_reg;
    logic [XW-1:0]        numag_reg;
    logic                 neg3_reg, zero3_reg;
    logic [XW-1:0]        dmag4_reg;
    logic [RW-1:0]        rem4_reg;
    sit_flags_t           flags4_reg;
    sit_flags_t           flags4_next;

    assign src_v = {v_reg[NS-2:0], in_valid};

    always_comb
    begin
        rdy[NS-1] = !v_reg[NS-1] || cells_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        for (int k = 0; k < NS; k++)
        begin
            v_next[k] = rdy[k] ? src_v[k] : v_reg[k];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        flags4_next.neg  = neg3_reg;
        flags4_next.zero = zero3_reg;
        flags4_next.hit  = (ntn_reg > 0) && (ntn_reg < dmag3_reg)
                           && (nun_reg > 0) && (nun_reg < dmag3_reg);
        flags4_next.ovf  = ((RW'(numag_reg) << FRAC_BITS) >= (RW'(dmag3_reg) << CW));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && src_v[0])
        begin
            rx_reg <= $signed({p2_x[CW-1], p2_x[CW-1:0]}) - $signed({p1_x[CW-1], p1_x[CW-1:0]});
            ry_reg <= $signed({p2_y[CW-1], p2_y[CW-1:0]}) - $signed({p1_y[CW-1], p1_y[CW-1:0]});
            sx_reg <= $signed({q2_x[CW-1], q2_x[CW-1:0]}) - $signed({q1_x[CW-1], q1_x[CW-1:0]});
            sy_reg <= $signed({q2_y[CW-1], q2_y[CW-1:0]}) - $signed({q1_y[CW-1], q1_y[CW-1:0]});
            wx_reg <= $signed({q1_x[CW-1], q1_x[CW-1:0]}) - $signed({p1_x[CW-1], p1_x[CW-1:0]});
            wy_reg <= $signed({q1_y[CW-1], q1_y[CW-1:0]}) - $signed({p1_y[CW-1], p1_y[CW-1:0]});
        end
        if (rdy[1] && src_v[1])
        begin
            m_rxsy_reg <= rx_reg * sy_reg;
            m_rysx_reg <= ry_reg * sx_reg;
            m_wxsy_reg <= wx_reg * sy_reg;
            m_wysx_reg <= wy_reg * sx_reg;
            m_wxry_reg <= wx_reg * ry_reg;
            m_wyrx_reg <= wy_reg * rx_reg;
        end
        if (rdy[2] && src_v[2])
        begin
            d_reg  <= $signed({m_rxsy_reg[PW-1], m_rxsy_reg})
                      - $signed({m_rysx_reg[PW-1], m_rysx_reg});
            nt_reg <= $signed({m_wxsy_reg[PW-1], m_wxsy_reg})
                      - $signed({m_wysx_reg[PW-1], m_wysx_reg});
            nu_reg <= $signed({m_wxry_reg[PW-1], m_wxry_reg})
                      - $signed({m_wyrx_reg[PW-1], m_wyrx_reg});
        end
        if (rdy[3] && src_v[3])
        begin
            dmag3_reg <= d_reg[XW-1] ? -d_reg : d_reg;
            ntn_reg   <= d_reg[XW-1] ? -nt_reg : nt_reg;
            nun_reg   <= d_reg[XW-1] ? -nu_reg : nu_reg;
            numag_reg <= nu_reg[XW-1] ? XW'(-nu_reg) : XW'(nu_reg);
            neg3_reg  <= nu_reg[XW-1] ^ d_reg[XW-1];
            zero3_reg <= (d_reg == '0);
        end
        if (rdy[4] && src_v[4])
        begin
            dmag4_reg  <= XW'(dmag3_reg);
            rem4_reg   <= RW'(numag_reg) << FRAC_BITS;
            flags4_reg <= flags4_next;
        end
    end

    logic [CW:0]         c_valid;
    logic [CW:0]         c_ready;
    logic [RW-1:0]       c_rem   [CW+1];
    logic [XW-1:0]       c_dmag  [CW+1];
    logic [CW-1:0]       c_quo   [CW+1];
    sit_flags_t          c_flags [CW+1];

    assign c_valid[0] = v_reg[NS-1];
    assign cells_ready = c_ready[0];
    assign c_rem[0]   = rem4_reg;
    assign c_dmag[0]  = dmag4_reg;
    assign c_quo[0]   = '0;
    assign c_flags[0] = flags4_reg;

    genvar g;
    generate
        for (g = 0; g < CW; g++)
        begin : g_cell
            sit_div_cell #(
                .CW  (CW),
                .XW  (XW),
                .RW  (RW),
                .BIT (CW - 1 - g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (c_valid[g]),
                .in_ready  (c_ready[g]),
                .rem_in    (c_rem[g]),
                .dmag_in   (c_dmag[g]),
                .quo_in    (c_quo[g]),
                .flags_in  (c_flags[g]),
                .out_valid (c_valid[g+1]),
                .out_ready (c_ready[g+1]),
                .rem_out   (c_rem[g+1]),
                .dmag_out  (c_dmag[g+1]),
                .quo_out   (c_quo[g+1]),
                .flags_out (c_flags[g+1])
            );
        end
    endgenerate

    logic                   ovalid_reg;
    logic                   ovalid_next;
    logic [FIELD_WIDTH-1:0] u_reg;
    logic [FIELD_WIDTH-1:0] u_next;
    logic                   hit_reg;
    logic                   oready;
    logic [CW-1:0]          limit;
    logic [CW-1:0]          mag;
    logic [CW-1:0]          val;
    sit_flags_t             fl;

    assign oready = !ovalid_reg || out_ready;
    assign c_ready[CW] = oready;
    assign fl = c_flags[CW];

    always_comb
    begin
        limit = fl.neg ? (CW'(1) << (CW - 1)) : ((CW'(1) << (CW - 1)) - CW'(1));
        mag   = (fl.ovf || (c_quo[CW] > limit)) ? limit : c_quo[CW];
        val   = fl.neg ? -mag : mag;
        u_next = fl.zero ? '0 : FIELD_WIDTH'($signed(val));
        ovalid_next = oready ? c_valid[CW] : ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oready && c_valid[CW])
        begin
            u_reg   <= u_next;
            hit_reg <= fl.hit && !fl.zero;
        end
    end

    assign out_valid = ovalid_reg;
    assign u_param   = u_reg;
    assign hit       = hit_reg;

endmodule

>>> hw/rtl/sit_checker.sv
module sit_checker
    import sit_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [FIELD_WIDTH-1:0] u_param,
    input logic                   hit
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under backpressure");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(u_param) && $stable(hit))
        else $error("result changed under backpressure");

    a_hit_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !u_param[FIELD_WIDTH-1])
        else $error("hit with negative u_param");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind segment_intersection_test_unit sit_checker u_sit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .u_param   (u_param),
    .hit       (hit)
);
